// File: rtl/pvu_pkg.sv
// Shared types, constants and helper functions of the probability vector unit.
`timescale 1ns / 1ps

package pvu_pkg;

    // Default parameter values.
    localparam int DEPTH_DEF     = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Field widths.
    localparam int VAL_W     = 26;
    localparam int RATE_W    = 17;
    localparam int IDX_W     = 8;
    localparam int DIV_W     = 12;
    localparam int RND_W     = 16;
    localparam int OP_W      = 3;
    localparam int RATE_FRAC = 16;

    // Internal arithmetic widths.
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = RATE_W + 1 + DIFF_W;
    localparam int SUM_W  = VAL_W + 4;

    // Stream and register port widths.
    localparam int S_DATA_W = 120;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 1;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Bit positions of the fields in the input tdata.
    localparam int F_IDX_LO = 0;
    localparam int F_BIT    = F_IDX_LO + IDX_W;
    localparam int F_TGT_LO = F_BIT + 1;
    localparam int F_SUB_LO = F_TGT_LO + VAL_W;
    localparam int F_RND_LO = F_SUB_LO + VAL_W;
    localparam int F_WGT_LO = F_RND_LO + RND_W;
    localparam int F_DIV_LO = F_WGT_LO + VAL_W;

    // Reset values of the configuration registers.
    localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(6554);
    localparam logic [VAL_W-1:0]  LOWER_RST = '0;
    localparam logic [VAL_W-1:0]  UPPER_RST = VAL_W'(65536);

    typedef logic signed [VAL_W-1:0] val_t;

    // Ends of the entry range.
    localparam val_t VAL_HI = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_LO = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    // Rounding offset for the rate product (one half in Q0.16).
    localparam logic signed [PROD_W-1:0] PROD_HALF =
        {{(PROD_W-RATE_FRAC){1'b0}}, 1'b1, {(RATE_FRAC-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE,
        OP_ADD_ONE,
        OP_ADD_WEIGHT,
        OP_DIVIDE,
        OP_UPD_BIT,
        OP_UPD_VALUE,
        OP_UPD_DIFF,
        OP_CLAMP
    } opcode_t;

    typedef enum logic [1:0] {
        REG_RATE,
        REG_LOWER,
        REG_UPPER
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        val_t              lower;
        val_t              upper;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             negative;
        logic [VAL_W-1:0] magnitude;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        val_t quotient;
    } div_rsp_t;

    typedef struct packed {
        val_t value;
        logic flag;
    } sat_t;

    // Sign-extends an entry value to the sum width.
    function automatic logic signed [SUM_W-1:0] sext_val(input val_t v);
        return $signed({{(SUM_W-VAL_W){v[VAL_W-1]}}, v});
    endfunction

    // Clips a wide sum to the entry range and flags when it had to.
    function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > SUM_HI) begin
            r.value = VAL_HI;
            r.flag  = 1'b1;
        end else if (v < SUM_LO) begin
            r.value = VAL_LO;
            r.flag  = 1'b1;
        end else begin
            r.value = $signed(v[VAL_W-1:0]);
            r.flag  = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/pvu_ram.sv
// Single-port-write, single-port-read synchronous memory holding the vector entries.
`timescale 1ns / 1ps

module pvu_ram #(
    parameter int DEPTH = pvu_pkg::DEPTH_DEF,
    parameter int WIDTH = pvu_pkg::VAL_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; returns the old contents on a same-cycle write.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pvu_div.sv
// Restoring divider that takes one quotient bit per cycle for the divide opcode.
`timescale 1ns / 1ps

module pvu_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  pvu_pkg::div_req_t  req,
    output pvu_pkg::div_rsp_t  rsp
);
    import pvu_pkg::*;

    localparam int CNT_W = $clog2(VAL_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic             neg_reg, neg_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W:0]   rem_shift;
    logic             fits;

    // One shift-and-subtract step per cycle; the dividend shifts out as
    // the quotient shifts in.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        dsr_next  = dsr_reg;
        rem_shift = {rem_reg, quo_reg[VAL_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.magnitude;
            neg_next  = req.negative;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DIV_W'(rem_shift - {1'b0, dsr_reg}) : rem_shift[DIV_W-1:0];
            quo_next = {quo_reg[VAL_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath state.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        dsr_reg <= dsr_next;
    end

    // Restore the sign; the quotient truncates toward zero.
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// File: rtl/pvu_regs.sv
// APB configuration registers: learning rate and clamp limits.
`timescale 1ns / 1ps

module pvu_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pvu_pkg::APB_AW-1:0]   paddr,
    input  logic [pvu_pkg::APB_DW-1:0]   pwdata,
    output logic [pvu_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output pvu_pkg::cfg_t                cfg
);
    import pvu_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[APB_AW-1:2]);

    // Write decode; addresses past the last register are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_RATE:  cfg_next.rate  = pwdata[RATE_W-1:0];
                REG_LOWER: cfg_next.lower = $signed(pwdata[VAL_W-1:0]);
                REG_UPPER: cfg_next.upper = $signed(pwdata[VAL_W-1:0]);
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate  <= RATE_RST;
            cfg_reg.lower <= $signed(LOWER_RST);
            cfg_reg.upper <= $signed(UPPER_RST);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read decode; the limits read back sign-extended.
    always_comb begin
        unique case (reg_sel)
            REG_RATE:  prdata = {{(APB_DW-RATE_W){1'b0}}, cfg_reg.rate};
            REG_LOWER: prdata = {{(APB_DW-VAL_W){cfg_reg.lower[VAL_W-1]}}, cfg_reg.lower};
            REG_UPPER: prdata = {{(APB_DW-VAL_W){cfg_reg.upper[VAL_W-1]}}, cfg_reg.upper};
            default:   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/probability_vector_unit.sv
// Top level of the probability vector unit: sequencer, arithmetic and stream ports.
// Each beat on the input stream names one vector entry and an operation; the unit
// reads the entry from its memory, applies the operation, writes it back and sends
// one result beat. Ordinary operations run back to back: the execute state does the
// memory read and the rate multiply, the write-back state the rounding add, saturation
// and write-back, which overlaps the read of the next beat (a same-entry hit is forwarded).
// A divide with a nonzero count runs through a one-bit-per-cycle divider between its
// execute and write-back states. A result beat that the receiver has not taken yet
// holds the write-back cycle until the output register frees up. After reset the unit
// zeroes every memory entry with s_tready low; configuration writes are taken at any time.
`timescale 1ns / 1ps

module probability_vector_unit #(
    parameter int DEPTH     = pvu_pkg::DEPTH_DEF,
    parameter int FRAC_BITS = pvu_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: element_index, bit_value, target_value, subtract_value,
    //        random_value, add_weight, divisor, zero padding
    input  logic [pvu_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: opcode
    input  logic [pvu_pkg::S_USER_W-1:0]  s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: sampled_bit, element_value, zero padding
    output logic [pvu_pkg::M_DATA_W-1:0]  m_tdata,
    // tuser: saturated
    output logic [pvu_pkg::M_USER_W-1:0]  m_tuser,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvu_pkg::APB_AW-1:0]    paddr,
    input  logic [pvu_pkg::APB_DW-1:0]    pwdata,
    output logic [pvu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pvu_pkg::*;

    localparam int   RAM_AW = $clog2(DEPTH);
    localparam int   CMP_W  = VAL_W + RND_W;
    localparam val_t ONE    = val_t'(1 << FRAC_BITS);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     div_start;

    state_t state_reg, state_next;
    logic [RAM_AW-1:0] clr_reg, clr_next;

    // Index wrap table, worked out at elaboration.
    logic [RAM_AW-1:0] idx_lut [2**IDX_W];
    logic [RAM_AW-1:0] in_addr;
    logic              accept;
    logic              out_free;

    // Memory port signals.
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    val_t              ram_wdata;
    logic [VAL_W-1:0]  ram_rdata;

    // Captured item.
    opcode_t           op_reg;
    logic [RAM_AW-1:0] idx_reg;
    logic              bit_reg;
    val_t              target_reg;
    val_t              sub_reg;
    logic [RND_W-1:0]  rnd_reg;
    val_t              weight_reg;
    logic [DIV_W-1:0]  divisor_reg;

    // Forwarding of a write-back to an immediately following read.
    logic fwd_reg;
    val_t fwd_data_reg;

    // Execute stage.
    val_t                      p_cur;
    logic signed [DIFF_W-1:0]  diff_c;
    logic signed [PROD_W-1:0]  prod_c;
    sat_t                      direct_c;
    logic                      sbit_c;
    logic                      rate_op_c;
    val_t                      clamp_c;
    logic [CMP_W-1:0]          rnd_cmp;
    logic [CMP_W-1:0]          p_cmp;

    val_t                      p_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    val_t                      val_reg;
    logic                      sat_reg;
    logic                      sbit_reg;
    logic                      use_rate_reg;

    // Write-back stage.
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [PROD_W-1:0]  prod_shift;
    sat_t                      rate_res;
    val_t                      wb_val;
    logic                      wb_flag;

    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;
    logic [M_USER_W-1:0]       m_tuser_reg;

    pvu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pvu_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    pvu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    for (genvar g = 0; g < 2**IDX_W; g++) begin : g_idx_lut
        assign idx_lut[g] = RAM_AW'(g % DEPTH);
    end

    assign in_addr  = idx_lut[s_tdata[F_IDX_LO +: IDX_W]];
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sequencer: clearing pass, then read, execute and write back per beat.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = wb_val;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == RAM_AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_DIVIDE && divisor_reg != '0) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (out_free) begin
                    s_tready   = 1'b1;
                    ram_we     = 1'b1;
                    state_next = s_tvalid ? ST_EXEC : ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Entry as seen by the execute stage.
    assign p_cur = fwd_reg ? fwd_data_reg : $signed(ram_rdata);

    // Divider request: sign and magnitude of the entry with the count.
    assign div_req = '{
        start:     div_start,
        negative:  p_cur[VAL_W-1],
        magnitude: p_cur[VAL_W-1] ? VAL_W'(-p_cur) : p_cur,
        divisor:   divisor_reg
    };

    // Difference that the learning rate scales, and its product.
    always_comb begin
        case (op_reg)
            OP_UPD_BIT:   diff_c = $signed({(bit_reg ? ONE[VAL_W-1] : 1'b0),
                                            (bit_reg ? ONE : val_t'(0))})
                                   - $signed({p_cur[VAL_W-1], p_cur});
            OP_UPD_VALUE: diff_c = $signed({target_reg[VAL_W-1], target_reg})
                                   - $signed({p_cur[VAL_W-1], p_cur});
            default:      diff_c = $signed({target_reg[VAL_W-1], target_reg})
                                   - $signed({sub_reg[VAL_W-1], sub_reg});
        endcase
    end

    assign prod_c = $signed({1'b0, cfg.rate}) * diff_c;

    // Clamp: the lower limit wins when the limits cross.
    always_comb begin
        clamp_c = p_cur;
        if (clamp_c > cfg.upper) begin
            clamp_c = cfg.upper;
        end
        if (clamp_c < cfg.lower) begin
            clamp_c = cfg.lower;
        end
    end

    // Sample compare: random word against the entry, both aligned to one scale.
    assign rnd_cmp = CMP_W'(rnd_reg) << FRAC_BITS;
    assign p_cmp   = CMP_W'(p_cur[VAL_W-2:0]) << RND_W;

    // Results that need no multiply.
    always_comb begin
        direct_c.value = p_cur;
        direct_c.flag  = 1'b0;
        sbit_c         = 1'b0;
        rate_op_c      = 1'b0;
        case (op_reg)
            OP_SAMPLE: begin
                sbit_c = !p_cur[VAL_W-1] && (p_cur != '0) && (rnd_cmp < p_cmp);
            end
            OP_ADD_ONE: begin
                if (bit_reg) begin
                    direct_c = saturate(sext_val(p_cur) + sext_val(ONE));
                end
            end
            OP_ADD_WEIGHT: begin
                if (bit_reg) begin
                    direct_c = saturate(sext_val(p_cur) + sext_val(weight_reg));
                end
            end
            OP_CLAMP: begin
                direct_c.value = clamp_c;
            end
            OP_UPD_BIT, OP_UPD_VALUE, OP_UPD_DIFF: begin
                rate_op_c = 1'b1;
            end
            default: begin
                direct_c.value = p_cur;
            end
        endcase
    end

    // Rounded rate term (ties toward plus infinity) added to the entry.
    assign prod_rnd   = prod_reg + PROD_HALF;
    assign prod_shift = prod_rnd >>> RATE_FRAC;
    assign rate_res   = saturate(sext_val(p_reg) + $signed(prod_shift[SUM_W-1:0]));
    assign wb_val     = use_rate_reg ? rate_res.value : val_reg;
    assign wb_flag    = use_rate_reg ? rate_res.flag : sat_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            fwd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fwd_reg   <= accept && (state_reg == ST_WB) && (in_addr == idx_reg);
            if (state_reg == ST_WB && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item capture, execute and write-back registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= opcode_t'(s_tuser[OP_W-1:0]);
            idx_reg      <= in_addr;
            bit_reg      <= s_tdata[F_BIT];
            target_reg   <= $signed(s_tdata[F_TGT_LO +: VAL_W]);
            sub_reg      <= $signed(s_tdata[F_SUB_LO +: VAL_W]);
            rnd_reg      <= s_tdata[F_RND_LO +: RND_W];
            weight_reg   <= $signed(s_tdata[F_WGT_LO +: VAL_W]);
            divisor_reg  <= s_tdata[F_DIV_LO +: DIV_W];
            fwd_data_reg <= wb_val;
        end
        if (state_reg == ST_EXEC) begin
            p_reg        <= p_cur;
            prod_reg     <= prod_c;
            val_reg      <= direct_c.value;
            sat_reg      <= direct_c.flag;
            sbit_reg     <= sbit_c;
            use_rate_reg <= rate_op_c;
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            val_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_WB && out_free) begin
            m_tdata_reg <= {{(M_DATA_W-VAL_W-1){1'b0}}, wb_val, sbit_reg};
            m_tuser_reg <= wb_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/pvu_checker.sv
// Port-level checks for the probability vector unit and their binding to the top level.
`timescale 1ns / 1ps

module pvu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pvu_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [pvu_pkg::M_USER_W-1:0]  m_tuser
);
    import pvu_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every accepted beat passes through the execute state before the next beat is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in the cycle after an accept");

    // Reset empties the output and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("ports active right after reset");

    // A saturated result sits on one end of the entry range.
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[VAL_W:1] == VAL_HI) || (m_tdata[VAL_W:1] == VAL_LO))
        else $error("saturated result is not at a range end");

    // Sampling never changes the entry, so it never saturates.
    a_sample_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tuser[0])
        else $error("sampled bit together with saturation");

endmodule

bind probability_vector_unit pvu_checker u_pvu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
